>>> hdl/crcdf_pkg.sv
// Package with the shared constants, phase codes and CRC helper of the CRC-16 frame deframer.
`default_nettype none
package crcdf_pkg;

	// Register reset values and frame constants.
	localparam logic [7:0] START_RESET = 8'h02;
	localparam logic [7:0] DIR_RESET = 8'h54;
	localparam logic [7:0] END_RESET = 8'h03;
	localparam logic [2:0] HEADER_BYTES = 3'd6;
	localparam logic [2:0] LEN_BYTES = 3'd4;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Configuration register indexes.
	localparam logic [1:0] CFG_START = 2'd0;
	localparam logic [1:0] CFG_DIR = 2'd1;
	localparam logic [1:0] CFG_END = 2'd2;

	// Deframer phase codes.
	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_DIR = 3'd1;
	localparam logic [2:0] PH_HEADER = 3'd2;
	localparam logic [2:0] PH_BODY = 3'd3;
	localparam logic [2:0] PH_BCRC = 3'd4;
	localparam logic [2:0] PH_END = 3'd5;

	// End status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_HDR_CRC = 2'd1;
	localparam logic [1:0] ST_BODY_CRC = 2'd2;
	localparam logic [1:0] ST_BAD_END = 2'd3;

	// Folds one byte into a reflected CRC-16/MODBUS value.
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> hdl/crc16_frame_deframer_top.sv
// Top level of the CRC-16 frame deframer: input register, frame state and result register.
// Usage:
// The input channel (in_valid, in_stall, rx_byte) takes one received byte per item.
// The block hunts for the start byte, waits for the direction byte, reads a 4-byte
// little-endian length and a 2-byte header CRC, then passes the body bytes out on the
// result channel (out_valid, out_stall, data_byte, in_type, last, status), the first
// two marked by in_type. After the body CRC and the end byte it sends one item with
// last set and a status code. Other bytes outside a body cause no result item.
// Throughput is one byte per cycle while the receiver does not stall: the CRC fold
// and the counters update once per byte in a single pass between the input register
// and the result register, which holds each result item for the receiver.
// When the receiver stalls, the result register holds and the input register holds
// one more byte, after which in_stall rises until the result is taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; the user must write it only while the block is idle (not enforced here).
// Reset clears both pipeline registers, returns to hunting and restores the
// register reset values.
`default_nettype none
module crc16_frame_deframer_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      data_byte,
	output logic            in_type,
	output logic            last,
	output logic [1:0]      status
);

	// Configuration registers.
	logic [7:0] start_byte_q;
	logic [7:0] dir_byte_q;
	logic [7:0] end_byte_q;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Frame state.
	logic [2:0]  phase_q;
	logic [2:0]  hdr_cnt_q;
	logic [31:0] len_q;
	logic [15:0] hdr_crc_q;
	logic [15:0] crc_q;
	logic [31:0] remain_q;
	logic [15:0] body_crc_q;
	logic        hdr_fail_q;
	logic [1:0]  type_cnt_q;

	// Next frame state and result.
	logic [2:0]  phase_d;
	logic [2:0]  hdr_cnt_d;
	logic [31:0] len_d;
	logic [15:0] hdr_crc_d;
	logic [15:0] crc_d;
	logic [31:0] remain_d;
	logic [15:0] body_crc_d;
	logic        hdr_fail_d;
	logic [1:0]  type_cnt_d;
	logic        res_d;
	logic [7:0]  res_byte_d;
	logic        res_type_d;
	logic        res_last_d;
	logic [1:0]  res_status_d;
	logic [15:0] crc_fold_b;
	logic [2:0]  hdr_cnt_inc;

	// Result register.
	logic       out_valid_q;
	logic [7:0] data_byte_q;
	logic       in_type_q;
	logic       last_q;
	logic [1:0] status_q;

	logic out_free;
	logic advance;

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !out_stall;
	assign advance = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	assign out_valid = out_valid_q;
	assign data_byte = data_byte_q;
	assign in_type = in_type_q;
	assign last = last_q;
	assign status = status_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= crcdf_pkg::START_RESET;
			dir_byte_q <= crcdf_pkg::DIR_RESET;
			end_byte_q <= crcdf_pkg::END_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == crcdf_pkg::CFG_START) begin
				start_byte_q <= cfg_data;
			end
			if (cfg_index == crcdf_pkg::CFG_DIR) begin
				dir_byte_q <= cfg_data;
			end
			if (cfg_index == crcdf_pkg::CFG_END) begin
				end_byte_q <= cfg_data;
			end
		end
	end

	// Input register: refills whenever it is empty or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame state machine: one byte per pass.
	always_comb begin
		phase_d = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d = len_q;
		hdr_crc_d = hdr_crc_q;
		crc_d = crc_q;
		remain_d = remain_q;
		body_crc_d = body_crc_q;
		hdr_fail_d = hdr_fail_q;
		type_cnt_d = type_cnt_q;
		res_d = 1'b0;
		res_byte_d = 8'h00;
		res_type_d = 1'b0;
		res_last_d = 1'b0;
		res_status_d = crcdf_pkg::ST_OK;
		crc_fold_b = crcdf_pkg::crc_fold(crc_q, byte_s1);
		hdr_cnt_inc = hdr_cnt_q + 3'd1;
		unique case (phase_q)
			crcdf_pkg::PH_DIR: begin
				if (byte_s1 == dir_byte_q) begin
					crc_d = crc_fold_b;
					hdr_cnt_d = 3'd0;
					len_d = 32'd0;
					hdr_crc_d = 16'd0;
					phase_d = crcdf_pkg::PH_HEADER;
				end
			end
			crcdf_pkg::PH_HEADER: begin
				if (hdr_cnt_q < crcdf_pkg::LEN_BYTES) begin
					crc_d = crc_fold_b;
					len_d = {byte_s1, len_q[31:8]};
				end else if (hdr_cnt_q == crcdf_pkg::LEN_BYTES) begin
					hdr_crc_d = {8'h00, byte_s1};
				end else begin
					hdr_crc_d = {byte_s1, hdr_crc_q[7:0]};
				end
				hdr_cnt_d = hdr_cnt_inc;
				// Header complete: check its CRC and size the body.
				if (hdr_cnt_inc >= crcdf_pkg::HEADER_BYTES) begin
					if (crc_d == hdr_crc_d) begin
						remain_d = len_d;
						hdr_fail_d = 1'b0;
					end else begin
						remain_d = 32'd0;
						hdr_fail_d = 1'b1;
					end
					crc_d = crcdf_pkg::CRC_INIT;
					type_cnt_d = 2'd0;
					hdr_cnt_d = 3'd0;
					body_crc_d = 16'd0;
					phase_d = (remain_d != 32'd0) ? crcdf_pkg::PH_BODY : crcdf_pkg::PH_BCRC;
				end
			end
			crcdf_pkg::PH_BODY: begin
				crc_d = crc_fold_b;
				res_d = 1'b1;
				res_byte_d = byte_s1;
				res_type_d = (type_cnt_q < 2'd2);
				if (type_cnt_q < 2'd2) begin
					type_cnt_d = type_cnt_q + 2'd1;
				end
				remain_d = remain_q - 32'd1;
				if (remain_d == 32'd0) begin
					hdr_cnt_d = 3'd0;
					body_crc_d = 16'd0;
					phase_d = crcdf_pkg::PH_BCRC;
				end
			end
			crcdf_pkg::PH_BCRC: begin
				if (hdr_cnt_q == 3'd0) begin
					body_crc_d = {8'h00, byte_s1};
					hdr_cnt_d = 3'd1;
				end else begin
					body_crc_d = {byte_s1, body_crc_q[7:0]};
					hdr_cnt_d = 3'd0;
					phase_d = crcdf_pkg::PH_END;
				end
			end
			crcdf_pkg::PH_END: begin
				res_d = 1'b1;
				res_last_d = 1'b1;
				// Bad end byte outranks a header failure, which outranks a body CRC error.
				priority if (byte_s1 != end_byte_q) begin
					res_status_d = crcdf_pkg::ST_BAD_END;
				end else if (hdr_fail_q) begin
					res_status_d = crcdf_pkg::ST_HDR_CRC;
				end else if (crc_q != body_crc_q) begin
					res_status_d = crcdf_pkg::ST_BODY_CRC;
				end else begin
					res_status_d = crcdf_pkg::ST_OK;
				end
				phase_d = crcdf_pkg::PH_HUNT;
				hdr_cnt_d = 3'd0;
			end
			default: begin
				// Hunting, and any unused code, looks for the start byte.
				phase_d = crcdf_pkg::PH_HUNT;
				if (byte_s1 == start_byte_q) begin
					crc_d = crcdf_pkg::crc_fold(crcdf_pkg::CRC_INIT, byte_s1);
					phase_d = crcdf_pkg::PH_DIR;
				end
			end
		endcase
	end

	// Frame state registers advance with each processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= crcdf_pkg::PH_HUNT;
			hdr_cnt_q <= 3'd0;
			len_q <= 32'd0;
			hdr_crc_q <= 16'd0;
			crc_q <= crcdf_pkg::CRC_INIT;
			remain_q <= 32'd0;
			body_crc_q <= 16'd0;
			hdr_fail_q <= 1'b0;
			type_cnt_q <= 2'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			len_q <= len_d;
			hdr_crc_q <= hdr_crc_d;
			crc_q <= crc_d;
			remain_q <= remain_d;
			body_crc_q <= body_crc_d;
			hdr_fail_q <= hdr_fail_d;
			type_cnt_q <= type_cnt_d;
		end
	end

	// Result register: loads when free, otherwise holds for the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_d) begin
			data_byte_q <= res_byte_d;
			in_type_q <= res_type_d;
			last_q <= res_last_d;
			status_q <= res_status_d;
		end
	end

	// A frame end item carries no body byte and no type mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> data_byte == 8'h00 && !in_type)
		else $error("end item carries body data");

	// Body byte items always report an ok status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == crcdf_pkg::ST_OK)
		else $error("body item carries a status");

	// The body phase is only entered with bytes left to pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == crcdf_pkg::PH_BODY |-> remain_q != 32'd0)
		else $error("body phase with zero remaining");

	// Upstream is stalled only while a byte waits behind a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without cause");

endmodule
`default_nettype wire

>>> tb/crc16_frame_deframer_checker.sv
// Checker for the CRC-16 frame deframer: predicts every result item and compares the outputs.
module crc16_frame_deframer_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       in_type,
	input  wire logic       last,
	input  wire logic [1:0] status,
	output int              fails,
	output int              pending,
	output int              n_body,
	output int              n_ends,
	output int              n_ok
);
	timeunit 1ns;
	timeprecision 1ps;

	// One result item as the deframer should present it.
	typedef struct packed {
		logic [7:0] data;
		logic       is_type;
		logic       is_last;
		logic [1:0] code;
	} deframed_t;

	deframed_t deframed_q[$];

	// Register copies.
	logic [7:0] start_b, dir_b, end_b;

	// Frame state of the predictor.
	logic [2:0]  ph;
	logic [2:0]  hdr_cnt;
	logic [31:0] len_sh;
	logic [15:0] hdr_crc_rx;
	logic [15:0] crc;
	logic [31:0] body_left;
	logic [15:0] body_crc_rx;
	logic        hdr_bad;
	logic [1:0]  type_cnt;

	int fail_cnt, body_cnt, end_cnt, ok_cnt;

	// Bit-serial CRC-16/MODBUS: the data bits are fed in LSB first next to the register.
	function automatic logic [15:0] modbus_fold(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = {1'b0, r[15:1]};
			if (fb) begin
				r = r ^ crcdf_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	// Advances the frame state by one received byte and queues any result item.
	task automatic deframe_byte(input logic [7:0] b);
		deframed_t r;
		case (ph)
			crcdf_pkg::PH_DIR: begin
				if (b == dir_b) begin
					crc = modbus_fold(crc, b);
					hdr_cnt = '0;
					len_sh = '0;
					hdr_crc_rx = '0;
					ph = crcdf_pkg::PH_HEADER;
				end
			end
			crcdf_pkg::PH_HEADER: begin
				if (hdr_cnt < crcdf_pkg::LEN_BYTES) begin
					crc = modbus_fold(crc, b);
					len_sh = {b, len_sh[31:8]};
				end else if (hdr_cnt == crcdf_pkg::LEN_BYTES) begin
					hdr_crc_rx = {8'h00, b};
				end else begin
					hdr_crc_rx[15:8] = b;
				end
				hdr_cnt = hdr_cnt + 3'd1;
				if (hdr_cnt >= crcdf_pkg::HEADER_BYTES) begin
					// A failed header check drops the body and is reported at the end byte.
					if (crc == hdr_crc_rx) begin
						body_left = len_sh;
						hdr_bad = 1'b0;
					end else begin
						body_left = '0;
						hdr_bad = 1'b1;
					end
					crc = crcdf_pkg::CRC_INIT;
					type_cnt = '0;
					hdr_cnt = '0;
					body_crc_rx = '0;
					ph = (body_left != 0) ? crcdf_pkg::PH_BODY : crcdf_pkg::PH_BCRC;
				end
			end
			crcdf_pkg::PH_BODY: begin
				crc = modbus_fold(crc, b);
				r = '{data: b, is_type: (type_cnt < 2'd2), is_last: 1'b0,
					code: crcdf_pkg::ST_OK};
				deframed_q = {deframed_q, r};
				if (type_cnt < 2'd2) begin
					type_cnt = type_cnt + 2'd1;
				end
				body_left = body_left - 32'd1;
				if (body_left == 0) begin
					hdr_cnt = '0;
					body_crc_rx = '0;
					ph = crcdf_pkg::PH_BCRC;
				end
			end
			crcdf_pkg::PH_BCRC: begin
				if (hdr_cnt == 0) begin
					body_crc_rx = {8'h00, b};
					hdr_cnt = 3'd1;
				end else begin
					body_crc_rx[15:8] = b;
					hdr_cnt = '0;
					ph = crcdf_pkg::PH_END;
				end
			end
			crcdf_pkg::PH_END: begin
				// A bad end byte wins over a header error, which wins over a body error.
				r = '{data: 8'h00, is_type: 1'b0, is_last: 1'b1, code: crcdf_pkg::ST_OK};
				if (b != end_b) begin
					r.code = crcdf_pkg::ST_BAD_END;
				end else if (hdr_bad) begin
					r.code = crcdf_pkg::ST_HDR_CRC;
				end else if (crc != body_crc_rx) begin
					r.code = crcdf_pkg::ST_BODY_CRC;
				end
				deframed_q = {deframed_q, r};
				ph = crcdf_pkg::PH_HUNT;
				hdr_cnt = '0;
			end
			default: begin
				ph = crcdf_pkg::PH_HUNT;
				if (b == start_b) begin
					crc = modbus_fold(crcdf_pkg::CRC_INIT, b);
					ph = crcdf_pkg::PH_DIR;
				end
			end
		endcase
	endtask

	// Watch the three channels; results are compared before new input is predicted.
	always @(posedge clk or negedge arst_n) begin
		deframed_t want;
		if (!arst_n) begin
			start_b = crcdf_pkg::START_RESET;
			dir_b = crcdf_pkg::DIR_RESET;
			end_b = crcdf_pkg::END_RESET;
			ph = crcdf_pkg::PH_HUNT;
			hdr_cnt = '0;
			len_sh = '0;
			hdr_crc_rx = '0;
			crc = crcdf_pkg::CRC_INIT;
			body_left = '0;
			body_crc_rx = '0;
			hdr_bad = 1'b0;
			type_cnt = '0;
			deframed_q.delete();
		end else begin
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
				case (cfg_index)
					crcdf_pkg::CFG_START: start_b = cfg_data;
					crcdf_pkg::CFG_DIR:   dir_b = cfg_data;
					crcdf_pkg::CFG_END:   end_b = cfg_data;
					default:   ;
				endcase
			end
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (last === 1'b1) begin
					end_cnt++;
					if (status === crcdf_pkg::ST_OK) begin
						ok_cnt++;
					end
				end else begin
					body_cnt++;
				end
				if (deframed_q.size() == 0) begin
					if (fail_cnt < 10) begin
						$display("frame_chk: unexpected item data %02h type %b last %b status %0d",
							data_byte, in_type, last, status);
					end
					fail_cnt++;
				end else begin
					want = deframed_q.pop_front();
					if (data_byte !== want.data || in_type !== want.is_type ||
						last !== want.is_last || status !== want.code) begin
						if (fail_cnt < 10) begin
							$display("frame_chk: expected data %02h type %b last %b status %0d,",
								want.data, want.is_type, want.is_last, want.code);
							$display("frame_chk:   got data %02h type %b last %b status %0d",
								data_byte, in_type, last, status);
						end
						fail_cnt++;
					end
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				deframe_byte(rx_byte);
			end
		end
		fails <= fail_cnt;
		pending <= deframed_q.size();
		n_body <= body_cnt;
		n_ends <= end_cnt;
		n_ok <= ok_cnt;
	end

endmodule

>>> tb/crc16_frame_deframer_top_tb.sv
// Testbench top for the CRC-16 frame deframer: clock, reset, frame stimulus and verdict.
module crc16_frame_deframer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES = 8;
	localparam int BYTES_PER_SETTING = 120;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = crcdf_pkg::CFG_START;
	logic [7:0] cfg_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] data_byte;
	logic       in_type;
	logic       last;
	logic [1:0] status;

	int fails, pending, n_body, n_ends, n_ok;

	// Current register values, used to build frames.
	logic [7:0] cur_start = crcdf_pkg::START_RESET;
	logic [7:0] cur_dir = crcdf_pkg::DIR_RESET;
	logic [7:0] cur_end = crcdf_pkg::END_RESET;

	bit tx_nogap = 1'b0;
	bit rx_nogap = 1'b0;
	bit hold_req = 1'b0;
	int n_sent, n_noise, n_holds;

	crc16_frame_deframer_top dut (.*);

	crc16_frame_deframer_checker frame_chk (.*);

	always #5 clk = ~clk;

	// Run limit.
	initial begin
		#2_000_000;
		$display("crc16_frame_deframer_top: mismatch");
		$finish;
	end

	// Offers one byte and returns at the edge that accepts it.
	task automatic put_byte(input logic [7:0] b, input bit ignored);
		int gap;
		gap = tx_nogap ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		n_sent++;
		if (ignored) begin
			n_noise++;
		end
	endtask

	// Writes one register; cfg_valid is lowered by the caller after the last write.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
	endtask

	// Waits until the block is idle, then rewrites all three registers.
	task automatic set_config(input logic [7:0] s, input logic [7:0] d, input logic [7:0] e);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(crcdf_pkg::CFG_START, s);
		write_reg(crcdf_pkg::CFG_DIR, d);
		write_reg(crcdf_pkg::CFG_END, e);
		cfg_valid <= 1'b0;
		cur_start = s;
		cur_dir = d;
		cur_end = e;
	endtask

	// Sends one frame, optionally with junk ahead of the markers and with damaged parts.
	task automatic send_frame(input logic [31:0] len, input bit bad_hdr, input bit bad_body,
		input bit bad_end, input int n_pre, input int n_mid, input bit extreme);
		logic [15:0] hc, bc;
		logic [7:0]  b;
		int          n;
		for (int i = 0; i < n_pre; i++) begin
			b = 8'($urandom);
			if (b == cur_start) begin
				b = b ^ 8'h01;
			end
			put_byte(b, 1'b1);
		end
		put_byte(cur_start, 1'b0);
		hc = crcdf_pkg::crc_fold(crcdf_pkg::CRC_INIT, cur_start);
		for (int i = 0; i < n_mid; i++) begin
			b = 8'($urandom);
			if (b == cur_dir) begin
				b = b ^ 8'h80;
			end
			put_byte(b, 1'b1);
		end
		put_byte(cur_dir, 1'b0);
		hc = crcdf_pkg::crc_fold(hc, cur_dir);
		for (int i = 0; i < 4; i++) begin
			put_byte(len[8*i +: 8], 1'b0);
			hc = crcdf_pkg::crc_fold(hc, len[8*i +: 8]);
		end
		if (bad_hdr) begin
			hc = hc ^ (16'h0001 << $urandom_range(0, 15));
		end
		put_byte(hc[7:0], 1'b0);
		put_byte(hc[15:8], 1'b0);
		// A failed header means the block expects no body bytes.
		n = bad_hdr ? 0 : int'(len);
		bc = crcdf_pkg::CRC_INIT;
		for (int i = 0; i < n; i++) begin
			if (extreme) begin
				b = (i % 2 != 0) ? 8'hFF : 8'h00;
			end else begin
				b = 8'($urandom);
			end
			put_byte(b, 1'b0);
			bc = crcdf_pkg::crc_fold(bc, b);
		end
		if (bad_body) begin
			bc = bc ^ (16'h0001 << $urandom_range(0, 15));
		end
		put_byte(bc[7:0], 1'b0);
		put_byte(bc[15:8], 1'b0);
		b = cur_end;
		if (bad_end) begin
			b = b ^ 8'($urandom_range(1, 255));
		end
		put_byte(b, 1'b0);
	endtask

	// Mix of mostly clean frames, damaged frames and raw noise.
	task automatic run_traffic(input int frame_bytes);
		int          base, r;
		logic [31:0] len;
		base = n_sent - n_noise;
		while (n_sent - n_noise - base < frame_bytes) begin
			tx_nogap = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 12) begin
				repeat ($urandom_range(1, 6)) put_byte(8'($urandom), 1'b1);
			end else if (r < 22) begin
				send_frame($urandom, 1'b1, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
					$urandom_range(0, 2), $urandom_range(0, 1), 1'b0);
			end else begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
				send_frame(len, 1'b0, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
					$urandom_range(0, 2), $urandom_range(0, 1), 1'b0);
			end
		end
	endtask

	// Result receiver: random stalls per item, with a long hold-off on request.
	initial begin
		int n;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				n_holds++;
			end else begin
				n = rx_nogap ? 0 : $urandom_range(0, 10);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if ($urandom_range(0, 24) == 0) begin
				rx_nogap = !rx_nogap;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: junk while hunting and while waiting for the direction byte,
		// a two-byte body of extreme values, then a failed header with maximum length.
		put_byte(8'hFF, 1'b1);
		send_frame(32'd2, 1'b0, 1'b0, 1'b0, 0, 1, 1'b1);
		send_frame(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);

		// Random traffic under several register settings.
		run_traffic(BYTES_PER_SETTING);
		set_config(8'h00, 8'hFF, 8'h00);
		run_traffic(BYTES_PER_SETTING);
		set_config(8'hFF, 8'h00, 8'hFF);
		// Long receiver hold-off while a long body streams in back to back.
		hold_req = 1'b1;
		tx_nogap = 1'b1;
		send_frame(32'd40, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
		run_traffic(BYTES_PER_SETTING);
		set_config(8'($urandom), 8'($urandom), 8'($urandom));
		run_traffic(BYTES_PER_SETTING);
		set_config(8'($urandom), 8'($urandom), 8'($urandom));
		run_traffic(BYTES_PER_SETTING);

		// Drain, then give stray items time to show up.
		in_valid <= 1'b0;
		@(posedge clk);
		for (int k = 0; k < 5000 && pending != 0; k++) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run sent %0d bytes (%0d junk or noise) under five register settings",
			n_sent, n_noise);
		$display("with %0d long receiver hold-off(s); checked %0d body bytes and %0d frame ends,",
			n_holds, n_body, n_ends);
		$display("%0d of the frame ends with good status.", n_ok);
		if (fails == 0 && pending == 0) begin
			$display("crc16_frame_deframer_top: match");
		end else begin
			$display("crc16_frame_deframer_top: mismatch");
		end
		$finish;
	end

endmodule
